// ===== src/tbpf_pkg.sv =====
// tbpf_pkg: shared types, sizes and helpers for the tile background pixel fetch
// holds the word structs, request and register codes and the 1555 color expander
// no dependencies
package tbpf_pkg;

  localparam int VIDEO_MEM_BYTES = 524288;
  localparam int COLOR_MEM_BYTES = 4096;
  localparam int VAW = $clog2(VIDEO_MEM_BYTES);
  localparam int CAW = $clog2(COLOR_MEM_BYTES);
  localparam int VROWS = VIDEO_MEM_BYTES / 4;
  localparam int CROWS = COLOR_MEM_BYTES / 4;
  localparam int CFG_W = 27;

  typedef enum logic [1:0] {
    REQ_VRAM_WR = 2'd0,
    REQ_CRAM_WR = 2'd1,
    REQ_FETCH   = 2'd2,
    REQ_NONE    = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    CFG_LAYER_CTL = 3'd0,
    CFG_PNAME_CTL = 3'd1,
    CFG_MAP_SEL   = 3'd2,
    CFG_SCROLL_X  = 3'd3,
    CFG_SCROLL_Y  = 3'd4
  } cfg_index_t;

  localparam logic [1:0] CMODE_24 = 2'd2;
  localparam logic [1:0] CMODE_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [18:0] mem_addr;
    logic [7:0]  write_byte;
    logic [9:0]  pixel_x;
    logic [8:0]  pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [23:0] color_rgb;
    logic        is_transparent;
  } out_item_t;

  // 0bgr1555 to packed 8-bit red, green, blue
  function automatic logic [23:0] expand1555(input logic [15:0] w);
    expand1555 = {w[4:0], w[4:2], w[9:5], w[9:7], w[14:10], w[14:12]};
  endfunction

endpackage

// ===== src/tile_background_pixel_fetch.sv =====
// tile_background_pixel_fetch: one scrolling tile-map background layer
// five-stage pipeline with video and color memories; uses tbpf_pkg
// config registers are held here and read by every stage

// The layer takes one word per clock when not stalled: a video memory byte write,
// a color memory byte write or a pixel fetch. A fetch passes address, name read,
// dot read, palette read and output register to its result; writes give none.
// Unstalled throughput is one word per cycle, set by the single read port per
// stage on each memory. The one exception: a fetch that directly follows a video
// memory write is held back, because the write lands in the dot-read stage while
// the fetch would read its pattern name in the stage before. Both memories come up
// undefined; read only what software has loaded. Write registers only while idle.
module tile_background_pixel_fetch
  import tbpf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // config registers
  logic [11:0] layer_ctl_r;
  logic [15:0] pname_ctl_r;
  logic [26:0] map_sel_r;
  logic [15:0] scroll_x_r;
  logic [15:0] scroll_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_ctl_r <= 12'd64;
      pname_ctl_r <= '0;
      map_sel_r   <= '0;
      scroll_x_r  <= '0;
      scroll_y_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LAYER_CTL: layer_ctl_r <= cfg_wdata[11:0];
        CFG_PNAME_CTL: pname_ctl_r <= cfg_wdata[15:0];
        CFG_MAP_SEL:   map_sel_r   <= cfg_wdata[26:0];
        CFG_SCROLL_X:  scroll_x_r  <= cfg_wdata[15:0];
        CFG_SCROLL_Y:  scroll_y_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic [2:0] depth;
  logic       big, tp_en, one_word, aux, d0, d1, direct;
  logic [1:0] psize, cmode;
  logic [2:0] coff, bank;
  logic [9:0] supp;

  assign depth    = layer_ctl_r[2:0];
  assign big      = layer_ctl_r[3];
  assign psize    = layer_ctl_r[5:4];
  assign tp_en    = layer_ctl_r[6];
  assign cmode    = layer_ctl_r[8:7];
  assign coff     = layer_ctl_r[11:9];
  assign one_word = pname_ctl_r[15];
  assign aux      = pname_ctl_r[14];
  assign bank     = pname_ctl_r[6:4];
  assign supp     = pname_ctl_r[9:0];
  assign d0       = (depth == 3'd0);
  assign d1       = (depth == 3'd1);
  assign direct   = !d0 && !d1;

  // pipeline control: all stages move together
  logic en, hazard, accept;
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  in_item_t it1_r, it2_r, it3_r;
  logic fetch4_r;

  assign en     = !out_valid_r || !out_stall;
  assign hazard = v1_r && (it1_r.req_type == REQ_VRAM_WR) && (in_data.req_type == REQ_FETCH);
  assign in_stall = !en || hazard;
  assign accept = in_valid && !in_stall;

  // stage 1: scroll, plane and name address
  logic [10:0] px, py;
  logic        px2, py2, px_hi, py_hi;
  logic [9:0]  lx, ly;
  logic [1:0]  plane, shift;
  logic [5:0]  psel;
  logic [8:0]  sel9, selm;
  logic [3:0]  sel_bits, pb_log;
  logic [11:0] cidx;
  logic [23:0] base, map24;
  logic [VAW-1:0] naddr;

  always_comb begin
    px    = {1'b0, it1_r.pixel_x} + scroll_x_r[10:0];
    py    = {2'b00, it1_r.pixel_y} + scroll_y_r[10:0];
    px2   = (psize == 2'd1) || (psize == 2'd3);
    py2   = (psize == 2'd3);
    px_hi = px2 ? px[10] : px[9];
    py_hi = py2 ? py[10] : py[9];
    lx    = px2 ? px[9:0] : {1'b0, px[8:0]};
    ly    = py2 ? py[9:0] : {1'b0, py[8:0]};
    plane = {py_hi, px_hi};
    case (plane)
      2'd0:    psel = map_sel_r[5:0];
      2'd1:    psel = map_sel_r[11:6];
      2'd2:    psel = map_sel_r[17:12];
      default: psel = map_sel_r[23:18];
    endcase
    sel9  = {map_sel_r[26:24], psel};
    shift = (psize == 2'd1) ? 2'd1 : ((psize == 2'd3) ? 2'd2 : 2'd0);
    sel_bits = one_word ? (big ? 4'd9 : 4'd7) : (big ? 4'd8 : 4'd6);
    pb_log   = one_word ? (big ? 4'd11 : 4'd13) : (big ? 4'd12 : 4'd14);
    // base = masked select above the page bits, times the page size
    selm  = sel9 & ((9'd1 << sel_bits) - 9'd1) & ~((9'd1 << shift) - 9'd1);
    base  = 24'(selm) << pb_log;
    cidx  = big ? {2'b00, ly[8:4], lx[8:4]} : {ly[8:3], lx[8:3]};
    map24 = base + (24'({ly[9], lx[9]}) << pb_log)
            + (one_word ? (24'(cidx) << 1) : (24'(cidx) << 2));
    naddr = map24[VAW-1:0];
  end

  // stage 2: pattern name decode and dot address
  logic [3:0]  cx2_r, cy2_r;
  logic        hsel2_r;
  logic [3:0][7:0] nrow_r;
  logic [15:0] w0, w1, wn;
  logic [14:0] chr;
  logic [6:0]  pal;
  logic        fh, fv;
  logic [3:0]  cxf, cyf;
  logic [1:0]  sub;
  logic [1:0]  ushift;
  logic [15:0] cellnum;
  logic [5:0]  pic;
  logic [6:0]  doff;
  logic [23:0] dadr24;
  logic [VAW-1:0] daddr;

  always_comb begin
    w0 = {nrow_r[0], nrow_r[1]};
    w1 = {nrow_r[2], nrow_r[3]};
    wn = hsel2_r ? w1 : w0;
    fh = 1'b0;
    fv = 1'b0;
    if (!one_word) begin
      chr = w1[14:0];
      pal = w0[6:0];
      fv  = w0[15];
      fh  = w0[14];
    end else begin
      if (!aux) begin
        fh  = wn[10];
        fv  = wn[11];
        chr = big ? {supp[4:2], wn[9:0], supp[1:0]} : {supp[4:0], wn[9:0]};
      end else begin
        chr = big ? {supp[4], wn[11:0], supp[1:0]} : {supp[4:2], wn[11:0]};
      end
      pal = d0 ? {bank, wn[15:12]} : {wn[14:12], 4'b0000};
    end
    cxf = big ? cx2_r : {1'b0, cx2_r[2:0]};
    cyf = big ? cy2_r : {1'b0, cy2_r[2:0]};
    if (fh) cxf = big ? ~cx2_r : {1'b0, ~cx2_r[2:0]};
    if (fv) cyf = big ? ~cy2_r : {1'b0, ~cy2_r[2:0]};
    sub     = big ? {cyf[3], cxf[3]} : 2'b00;
    ushift  = d0 ? 2'd0 : (d1 ? 2'd1 : 2'd2);
    cellnum = {1'b0, chr} + (16'(sub) << ushift);
    pic     = {cyf[2:0], cxf[2:0]};
    doff    = d0 ? {2'b00, pic[5:1]} : (d1 ? {1'b0, pic} : {pic, 1'b0});
    dadr24  = (24'(cellnum) << 5) + 24'(doff);
    daddr   = dadr24[VAW-1:0];
  end

  // stage 3: dot decode, transparency and palette address
  logic [6:0]  pal3_r;
  logic        pic0_3_r;
  logic [1:0]  dlow3_r;
  logic [3:0][7:0] drow_r;
  logic [7:0]  db;
  logic [3:0]  dot4;
  logic [15:0] dw;
  logic [11:0] cidx12;
  logic        trans3;
  logic [13:0] cofs;

  always_comb begin
    db   = drow_r[dlow3_r];
    dot4 = pic0_3_r ? db[3:0] : db[7:4];
    dw   = dlow3_r[1] ? {drow_r[2], drow_r[3]} : {drow_r[0], drow_r[1]};
    if (d0) begin
      cidx12 = 12'({coff, 8'h00}) + 12'({pal3_r, 4'h0}) + 12'(dot4);
      trans3 = tp_en && (dot4 == 4'd0);
    end else if (d1) begin
      cidx12 = 12'({coff, 8'h00}) + 12'({pal3_r[6:4], 8'h00}) + 12'(db);
      trans3 = tp_en && (db == 8'd0);
    end else begin
      cidx12 = '0;
      trans3 = (dw[14:0] == 15'd0);
    end
    cofs = (cmode == CMODE_24) ? {cidx12, 2'b00} : {1'b0, cidx12, 1'b0};
  end

  // stage 4: palette word select
  logic        trans4_r, chalf4_r;
  logic [14:0] dword4_r;
  logic [3:0][7:0] crow_r;
  logic [23:0] color4;

  always_comb begin
    if (direct) begin
      color4 = expand1555({1'b0, dword4_r});
    end else if (cmode == CMODE_NONE) begin
      color4 = '0;
    end else if (cmode == CMODE_24) begin
      color4 = {crow_r[3], crow_r[2], crow_r[1]};
    end else begin
      color4 = expand1555(chalf4_r ? {crow_r[2], crow_r[3]} : {crow_r[0], crow_r[1]});
    end
    if (trans4_r) color4 = '0;
  end

  // memories: video writes land in stage 2, color writes in stage 3
  logic [3:0][7:0] vmem [VROWS];
  logic [3:0][7:0] cmem [CROWS];
  logic [23:0] va2, ca3;

  assign va2 = 24'(it2_r.mem_addr);
  assign ca3 = 24'(it3_r.mem_addr);

  always_ff @(posedge clk) begin
    if (en) begin
      if (v2_r && (it2_r.req_type == REQ_VRAM_WR))
        vmem[va2[VAW-1:2]][va2[1:0]] <= it2_r.write_byte;
      nrow_r <= vmem[naddr[VAW-1:2]];
      drow_r <= vmem[daddr[VAW-1:2]];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (v3_r && (it3_r.req_type == REQ_CRAM_WR))
        cmem[ca3[CAW-1:2]][ca3[1:0]] <= it3_r.write_byte;
      crow_r <= cmem[cofs[CAW-1:2]];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      out_valid_r <= v4_r && fetch4_r;
    end
  end

  // payload through the stages
  always_ff @(posedge clk) begin
    if (en) begin
      it1_r    <= in_data;
      it2_r    <= it1_r;
      cx2_r    <= lx[3:0];
      cy2_r    <= ly[3:0];
      hsel2_r  <= naddr[1];
      it3_r    <= it2_r;
      pal3_r   <= pal;
      pic0_3_r <= pic[0];
      dlow3_r  <= daddr[1:0];
      fetch4_r <= (it3_r.req_type == REQ_FETCH);
      trans4_r <= trans3;
      chalf4_r <= cofs[1];
      dword4_r <= dw[14:0];
      out_data.color_rgb      <= color4;
      out_data.is_transparent <= trans4_r;
    end
  end

  assign out_valid = out_valid_r;

  // a fetch never reads names in the same cycle a video write lands
  a_no_name_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    !(v1_r && v2_r && (it2_r.req_type == REQ_VRAM_WR) && (it1_r.req_type == REQ_FETCH)))
    else $error("fetch read names during a video write");

  // a transparent word carries zero color
  a_trans_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data.is_transparent |-> (out_data.color_rgb == 24'd0))
    else $error("transparent word with nonzero color");

  // a held result keeps its valid while the pipeline is frozen
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(v4_r) && $stable(v1_r))
    else $error("pipeline moved while the output was stalled");

  // only fetches make results
  a_fetch_only: assert property (@(posedge clk) disable iff (!rst_n)
    en && v4_r && !fetch4_r |=> !out_valid_r)
    else $error("write produced a result");

endmodule
